// ----- sv/bfp_pkg.sv -----
// Shared types, constants and the arctangent table for the bearing pipeline.
package bfp_pkg;

  // Working widths: vector components and the fine angle accumulator
  localparam int VW = 38;
  localparam int AW = 31;
  localparam int OW = 21;
  localparam int TABLE_LEN = 24;

  // Fine angle constants, degrees with 20 fraction bits
  localparam logic signed [AW-1:0] DEG180_FINE = AW'(180 * (1 << 20));
  localparam logic signed [AW-1:0] DEG360_FINE = AW'(360 * (1 << 20));

  // Output angle constants, degrees with 12 fraction bits
  localparam logic [OW-1:0] DEG0_OUT   = OW'(0);
  localparam logic [OW-1:0] DEG90_OUT  = OW'(90 * 4096);
  localparam logic [OW-1:0] DEG180_OUT = OW'(180 * 4096);
  localparam logic [OW-1:0] DEG270_OUT = OW'(270 * 4096);
  localparam logic [OW:0]   DEG360_OUT = (OW+1)'(360 * 4096);

  // atan(2^-i) in degrees, 20 fraction bits
  localparam logic signed [AW-1:0] ARC_TABLE [TABLE_LEN] = '{
    AW'(47185920), AW'(27855475), AW'(14718068), AW'(7471121),
    AW'(3750058),  AW'(1876857),  AW'(938658),   AW'(469357),
    AW'(234682),   AW'(117342),   AW'(58671),    AW'(29335),
    AW'(14668),    AW'(7334),     AW'(3667),     AW'(1833),
    AW'(917),      AW'(458),      AW'(229),      AW'(115),
    AW'(57),       AW'(29),       AW'(14),       AW'(7)
  };

  // One pipeline beat moving between cells
  typedef struct packed {
    logic                  special;
    logic [OW-1:0]         special_val;
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic signed [AW-1:0]  acc;
  } work_t;

endpackage

// ----- sv/bearing_from_two_points_unit.sv -----
// Top level: compass bearing pipeline from two points.
//
// Input channel: in_valid/in_stall carrying first_x, first_y, second_x,
// second_y (signed Q2.16). A beat is taken when in_valid is high and
// in_stall is low. Output channel: out_valid/out_stall carrying
// bearing_deg, the clockwise angle from north in degrees with 12 fraction
// bits, 0 up to below 360. Equal points give 90 degrees.
// The pipeline is one entry register, one register per CORDIC
// micro-rotation cell and one output register. Throughput is one point
// pair per cycle while the receiver does not stall, set by the chain of
// rotation cells, each of which holds one beat.
// When the receiver stalls, the output register holds its beat and the
// chain keeps filling empty slots behind it; in_stall rises only once no
// stage ahead of the entry can move. Synchronous reset empties every
// stage; no beat is lost or repeated across stalls.
module bearing_from_two_points_unit #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [17:0]      first_x,
  input  logic signed [17:0]      first_y,
  input  logic signed [17:0]      second_x,
  input  logic signed [17:0]      second_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [20:0]             bearing_deg
);

  bfp_pkg::work_t stage_data  [ROTATION_STEPS+1];
  logic           stage_valid [ROTATION_STEPS+1];
  logic           stage_ready [ROTATION_STEPS+2];

  assign in_stall = !stage_ready[0];

  bfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .ready_out (stage_ready[1]),
    .ready_in  (stage_ready[0]),
    .valid     (stage_valid[0]),
    .data      (stage_data[0])
  );

  // Chain of micro-rotation cells
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
    bfp_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stage_valid[i]),
      .data_in   (stage_data[i]),
      .ready_out (stage_ready[i+2]),
      .ready_in  (stage_ready[i+1]),
      .valid     (stage_valid[i+1]),
      .data      (stage_data[i+1])
    );
  end

  bfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (stage_valid[ROTATION_STEPS]),
    .data_in     (stage_data[ROTATION_STEPS]),
    .out_stall   (out_stall),
    .ready_in    (stage_ready[ROTATION_STEPS+1]),
    .out_valid   (out_valid),
    .bearing_deg (bearing_deg)
  );

endmodule

// ----- sv/bfp_front.sv -----
// Entry stage: difference vector, axis cases and half-plane fold.
module bfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [17:0]  first_x,
  input  logic signed [17:0]  first_y,
  input  logic signed [17:0]  second_x,
  input  logic signed [17:0]  second_y,
  input  logic                ready_out,
  output logic                ready_in,
  output logic                valid,
  output bfp_pkg::work_t      data
);

  logic signed [18:0] dx;
  logic signed [18:0] dy;
  logic signed [18:0] dx_f;
  logic signed [18:0] dy_f;
  logic               south;
  bfp_pkg::work_t     data_next;

  assign ready_in = !valid || ready_out;

  // Form the difference vector and classify it
  always_comb begin
    dx = {second_x[17], second_x} - {first_x[17], first_x};
    dy = {second_y[17], second_y} - {first_y[17], first_y};
    south = dy[18];
    dx_f = south ? -dx : dx;
    dy_f = south ? -dy : dy;
    data_next.vx = {{(bfp_pkg::VW-35){dy_f[18]}}, dy_f, 16'b0};
    data_next.vy = {{(bfp_pkg::VW-35){dx_f[18]}}, dx_f, 16'b0};
    data_next.acc = south ? bfp_pkg::DEG180_FINE : '0;
    data_next.special = 1'b0;
    data_next.special_val = bfp_pkg::DEG0_OUT;
    if (dx == '0) begin
      data_next.special = 1'b1;
      if (dy == '0) begin
        data_next.special_val = bfp_pkg::DEG90_OUT;
      end else if (south) begin
        data_next.special_val = bfp_pkg::DEG180_OUT;
      end else begin
        data_next.special_val = bfp_pkg::DEG0_OUT;
      end
    end else if (dy == '0) begin
      data_next.special = 1'b1;
      data_next.special_val = dx[18] ? bfp_pkg::DEG270_OUT : bfp_pkg::DEG90_OUT;
    end
  end

  // Load a beat when this stage is free or drains
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      data <= data_next;
    end
  end

endmodule

// ----- sv/bfp_cell.sv -----
// One CORDIC vectoring micro-rotation cell of the pipeline chain.
module bfp_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  bfp_pkg::work_t  data_in,
  input  logic            ready_out,
  output logic            ready_in,
  output logic            valid,
  output bfp_pkg::work_t  data
);

  logic signed [bfp_pkg::VW-1:0] sx;
  logic signed [bfp_pkg::VW-1:0] sy;
  logic                          up;
  bfp_pkg::work_t                data_next;

  assign ready_in = !valid || ready_out;

  // Rotate toward the x axis and track the angle
  always_comb begin
    sx = data_in.vx >>> STEP;
    sy = data_in.vy >>> STEP;
    up = !data_in.vy[bfp_pkg::VW-1] && (data_in.vy != '0);
    data_next = data_in;
    if (up) begin
      data_next.vx  = data_in.vx + sy;
      data_next.vy  = data_in.vy - sx;
      data_next.acc = data_in.acc + bfp_pkg::ARC_TABLE[STEP];
    end else begin
      data_next.vx  = data_in.vx - sy;
      data_next.vy  = data_in.vy + sx;
      data_next.acc = data_in.acc - bfp_pkg::ARC_TABLE[STEP];
    end
  end

  // Advance when free or when the neighbor takes the held beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      data <= data_next;
    end
  end

endmodule

// ----- sv/bfp_back.sv -----
// Exit stage: fold into 0..360, round to 12 fraction bits, output register.
module bfp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  bfp_pkg::work_t              data_in,
  input  logic                        out_stall,
  output logic                        ready_in,
  output logic                        out_valid,
  output logic [bfp_pkg::OW-1:0]      bearing_deg
);

  logic signed [bfp_pkg::AW-1:0] acc_pos;
  logic [29:0]                   rnd;
  logic [bfp_pkg::OW:0]          res;
  logic [bfp_pkg::OW-1:0]        bearing_next;

  assign ready_in = !out_valid || !out_stall;

  // Wrap negative angles, round half up, fold 360 to 0
  always_comb begin
    acc_pos = data_in.acc[bfp_pkg::AW-1] ? data_in.acc + bfp_pkg::DEG360_FINE
                                         : data_in.acc;
    rnd = acc_pos[29:0] + 30'd128;
    res = rnd[29:8];
    if (res >= bfp_pkg::DEG360_OUT) begin
      res = res - bfp_pkg::DEG360_OUT;
    end
    bearing_next = data_in.special ? data_in.special_val : res[bfp_pkg::OW-1:0];
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_in) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      bearing_deg <= bearing_next;
    end
  end

endmodule

// ----- sv/bfp_checker.sv -----
// Port-level checks for the bearing pipeline, bound to the top level.
module bfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] bearing_deg
);

  // Result stays below 360 degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing_deg < 21'd1474560))
    else $error("bearing out of range");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bearing_deg)))
    else $error("stalled result changed");

  // An empty output means the pipeline can take an offered beat
  a_open: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind bearing_from_two_points_unit bfp_checker u_bfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bearing_deg (bearing_deg)
);

// ----- tb/sv/bearing_checker.sv -----
`timescale 1ns / 1ps
// Bearing checker: watches both channels, predicts each bearing and compares in order.
module bearing_checker #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [17:0] first_x,
  input  logic signed [17:0] first_y,
  input  logic signed [17:0] second_x,
  input  logic signed [17:0] second_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [20:0]        bearing_deg,
  output int                 mismatch_count,
  output int                 pending
);

  // Angles: fine values carry 20 fraction bits, output values 12
  localparam longint HALF_TURN_FINE = 64'sd180 <<< 20;
  localparam longint FULL_TURN_FINE = 64'sd360 <<< 20;
  localparam longint FULL_TURN_OUT  = 64'sd360 * 4096;
  localparam logic [20:0] NORTH_OUT = 21'd0;
  localparam logic [20:0] EAST_OUT  = 21'd90 * 21'd4096;
  localparam logic [20:0] SOUTH_OUT = 21'd180 * 21'd4096;
  localparam logic [20:0] WEST_OUT  = 21'd270 * 21'd4096;
  localparam int ARC_STEPS = 24;

  // atan(2^-i) in degrees, 20 fraction bits
  localparam longint ARC_FINE [ARC_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [17:0] fx;
    logic signed [17:0] fy;
    logic signed [17:0] sx;
    logic signed [17:0] sy;
    logic [20:0]        bearing;
  } bearing_exp_t;

  bearing_exp_t bearing_q [$];
  int errs = 0;

  // Clockwise angle from north of the vector first -> second
  function automatic logic [20:0] compass_bearing(input logic signed [17:0] fx,
                                                  input logic signed [17:0] fy,
                                                  input logic signed [17:0] sx,
                                                  input logic signed [17:0] sy);
    longint dx, dy, north, east, ang, north_sh, east_sh, rounded;
    dx = longint'(sx) - longint'(fx);
    dy = longint'(sy) - longint'(fy);
    // Vectors on an axis, and equal points, are exact
    if (dx == 0) begin
      if (dy > 0) return NORTH_OUT;
      if (dy < 0) return SOUTH_OUT;
      return EAST_OUT;
    end
    if (dy == 0) return (dx > 0) ? EAST_OUT : WEST_OUT;
    north = dy * 65536;
    east  = dx * 65536;
    ang   = 0;
    // Turn southern vectors by a half turn first
    if (north < 0) begin
      north = -north;
      east  = -east;
      ang   = HALF_TURN_FINE;
    end
    // Drive the east component to zero, accumulating the angle
    for (int i = 0; i < STEPS && i < ARC_STEPS; i++) begin
      north_sh = north >>> i;
      east_sh  = east >>> i;
      if (east > 0) begin
        north = north + east_sh;
        east  = east - north_sh;
        ang   = ang + ARC_FINE[i];
      end else begin
        north = north - east_sh;
        east  = east + north_sh;
        ang   = ang - ARC_FINE[i];
      end
    end
    // Fold into one turn, round half up to 12 fraction bits, wrap 360 to 0
    if (ang < 0) ang = ang + FULL_TURN_FINE;
    rounded = (ang + 128) >>> 8;
    if (rounded >= FULL_TURN_OUT) rounded = rounded - FULL_TURN_OUT;
    return rounded[20:0];
  endfunction

  // Queue a prediction per accepted pair, check each accepted bearing
  always @(posedge clk) begin : watch
    bearing_exp_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        e.fx = first_x;
        e.fy = first_y;
        e.sx = second_x;
        e.sy = second_y;
        e.bearing = compass_bearing(first_x, first_y, second_x, second_y);
        bearing_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (bearing_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("bearing %0d arrived with nothing pending", bearing_deg);
        end else begin
          e = bearing_q.pop_front();
          if (bearing_deg !== e.bearing) begin
            errs++;
            if (errs <= 10)
              $display("bearing mismatch (%0d,%0d)->(%0d,%0d): expected %0d got %0d",
                       e.fx, e.fy, e.sx, e.sy, e.bearing, bearing_deg);
          end
        end
      end
    end
    pending <= bearing_q.size();
    mismatch_count <= errs;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives point pairs into the bearing unit and reports the verdict.
module tb;

  localparam int STEPS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [17:0] CMAX = 18'sh1FFFF;
  localparam logic signed [17:0] CMIN = 18'sh20000;
  localparam logic signed [17:0] EDGE_VALS [5] = '{CMIN, CMAX, 18'sd0, -18'sd1, 18'sd1};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [17:0] first_x = '0;
  logic signed [17:0] first_y = '0;
  logic signed [17:0] second_x = '0;
  logic signed [17:0] second_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [20:0] bearing_deg;

  int idle_pct = 22;
  int stall_pct = 81;
  int mismatch_count;
  int pending;
  int cycles = 0;

  bearing_from_two_points_unit #(.ROTATION_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .out_valid(out_valid), .out_stall(out_stall), .bearing_deg(bearing_deg)
  );

  bearing_checker #(.STEPS(STEPS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .out_valid(out_valid), .out_stall(out_stall), .bearing_deg(bearing_deg),
    .mismatch_count(mismatch_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one point pair, with random idle cycles ahead, and hold it until taken
  task automatic send_pair(input logic signed [17:0] ax, input logic signed [17:0] ay,
                           input logic signed [17:0] bx, input logic signed [17:0] by);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x  <= ax;
    first_y  <= ay;
    second_x <= bx;
    second_y <= by;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random pair: free four times in ten, else near-equal, equal, on-axis, near-axis or extreme shapes
  task automatic send_random_pair();
    logic signed [17:0] ax, ay, bx, by;
    ax = 18'($urandom);
    ay = 18'($urandom);
    bx = 18'($urandom);
    by = 18'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4: begin
        bx = ax + 18'($urandom_range(16)) - 18'd8;
        by = ay + 18'($urandom_range(16)) - 18'd8;
      end
      5: bx = ax;
      6: by = ay;
      7: bx = ax + 18'($urandom_range(6)) - 18'd3;
      8: begin
        ax = EDGE_VALS[$urandom_range(4)];
        ay = EDGE_VALS[$urandom_range(4)];
        bx = EDGE_VALS[$urandom_range(4)];
        by = EDGE_VALS[$urandom_range(4)];
      end
      default: begin
        bx = ax;
        by = ay;
      end
    endcase
    send_pair(ax, ay, bx, by);
  endtask

  // Drop valid and hold off until every bearing is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Equal points, the four axes, extreme diagonals and near-axis vectors
    send_pair(18'sd0, 18'sd0, 18'sd0, 18'sd0);
    send_pair(18'sd12345, -18'sd777, 18'sd12345, -18'sd777);
    send_pair(CMIN, CMAX, CMIN, CMAX);
    send_pair(18'sd0, 18'sd0, 18'sd0, 18'sd100);
    send_pair(18'sd0, 18'sd0, 18'sd0, -18'sd100);
    send_pair(18'sd0, 18'sd0, 18'sd100, 18'sd0);
    send_pair(18'sd0, 18'sd0, -18'sd100, 18'sd0);
    send_pair(18'sd0, CMIN, 18'sd0, CMAX);
    send_pair(CMAX, 18'sd0, CMIN, 18'sd0);
    send_pair(CMIN, CMIN, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMIN, CMIN);
    send_pair(CMIN, CMAX, CMAX, CMIN);
    send_pair(CMAX, CMIN, CMIN, CMAX);
    send_pair(18'sd0, 18'sd0, 18'sd1, 18'sd1);
    send_pair(18'sd0, 18'sd0, 18'sd1, -18'sd1);
    send_pair(18'sd0, 18'sd0, -18'sd1, -18'sd1);
    send_pair(18'sd0, 18'sd0, -18'sd1, 18'sd1);
    send_pair(18'sd0, CMIN, 18'sd1, CMAX);
    send_pair(18'sd0, CMIN, -18'sd1, CMAX);
    send_pair(18'sd0, CMAX, 18'sd1, CMIN);
    send_pair(18'sd0, CMAX, -18'sd1, CMIN);
    send_pair(CMIN, 18'sd0, CMAX, 18'sd1);
    send_pair(CMAX, 18'sd0, CMIN, -18'sd1);

    // Sender mostly busy, receiver mostly stalled
    repeat (320) send_random_pair();
    drain();

    // Sender mostly idle, receiver mostly ready
    idle_pct = 81;
    stall_pct <= 22;
    repeat (330) send_random_pair();

    // Full rate on both sides
    idle_pct = 0;
    stall_pct <= 0;
    repeat (330) send_random_pair();
    drain();
    repeat (STEPS + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
